// ----- sv/ecn_count_threshold_marker_assert.svh -----
// ---------------------------------------------------------------------------
// ecn_count_threshold_marker_assert.svh
// Assertion macros shared by the ECN marker RTL.
// ---------------------------------------------------------------------------
`ifndef ECN_COUNT_THRESHOLD_MARKER_ASSERT_SVH
`define ECN_COUNT_THRESHOLD_MARKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECNTM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ecntm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECNTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ecntm: next-cycle check failed");

`endif

// ----- sv/ecntm_pkg.sv -----
// ---------------------------------------------------------------------------
// ecntm_pkg
// Types and codes of the ECN count-threshold marker.
// ---------------------------------------------------------------------------
`default_nettype none

package ecntm_pkg;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_DEQUEUED   = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_LIMIT_IN_BYTES     = 3'd0,
    CFG_PACKET_LIMIT       = 3'd1,
    CFG_BYTE_LIMIT         = 3'd2,
    CFG_COUNT_THRESHOLD    = 3'd3,
    CFG_PER_TENANT_COUNTS  = 3'd4,
    CFG_MARKING_ENABLED    = 3'd5,
    CFG_TENANT_ZERO_SOURCE = 3'd6,
    CFG_TENANT_ONE_SOURCE  = 3'd7
  } cfg_idx_e;

  // ECN codepoints
  localparam logic [1:0] ECN_NOT_ECT = 2'd0;
  localparam logic [1:0] ECN_ECT_1   = 2'd1;
  localparam logic [1:0] ECN_ECT0    = 2'd2;
  localparam logic [1:0] ECN_CE      = 2'd3;

  // Register reset values
  localparam logic        RST_LIMIT_IN_BYTES     = 1'b1;
  localparam logic [15:0] RST_PACKET_LIMIT       = 16'd4000;
  localparam logic [31:0] RST_BYTE_LIMIT         = 32'd6000000;
  localparam logic [15:0] RST_COUNT_THRESHOLD    = 16'd10;
  localparam logic        RST_PER_TENANT_COUNTS  = 1'b0;
  localparam logic        RST_MARKING_ENABLED    = 1'b1;
  localparam logic [31:0] RST_TENANT_ZERO_SOURCE = 32'h0A01_0101;  // 10.1.1.1
  localparam logic [31:0] RST_TENANT_ONE_SOURCE  = 32'h0A01_0201;  // 10.1.2.1

  typedef struct packed {
    logic        limit_in_bytes;
    logic [15:0] packet_limit;
    logic [31:0] byte_limit;
    logic [15:0] count_threshold;
    logic        per_tenant_counts;
    logic        marking_enabled;
    logic [31:0] tenant_zero_source;
    logic [31:0] tenant_one_source;
  } cfg_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] packet_bytes;
    logic [31:0] source_address;
    logic [1:0]  ecn_in;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  ecn_out;
    logic        was_marked;
    logic [15:0] tenant_zero_level;
    logic [15:0] tenant_one_level;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/ecntm_engine.sv -----
// ---------------------------------------------------------------------------
// ecntm_engine
// Occupancy and tenant counters with the admission / marking decision.
// ---------------------------------------------------------------------------
`default_nettype none

module ecntm_engine
  import ecntm_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire item_t   item_i,
  input  wire logic    commit_i,   // apply the state update of item_i
  output result_t      result_o
);

  localparam int unsigned CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int unsigned LVL_BITS = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] pkts_q, pkts_d;
  logic [31:0]           bytes_q, bytes_d;
  logic [COUNT_BITS-1:0] t0_q, t0_d;
  logic [COUNT_BITS-1:0] t1_q, t1_d;

  logic [32:0]           byte_sum;
  logic [CMP_BITS-1:0]   pkt_sum;
  logic                  full;
  logic [COUNT_BITS-1:0] level;
  logic                  unexpected;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_dec(input logic [COUNT_BITS-1:0] v);
    sat_dec = (v == '0) ? v : v - 1'b1;
  endfunction

  assign byte_sum = {1'b0, bytes_q} + {17'd0, item_i.packet_bytes};
  assign pkt_sum  = CMP_BITS'(pkts_q) + CMP_BITS'(1);
  assign full     = cfg_i.limit_in_bytes ? (byte_sum > {1'b0, cfg_i.byte_limit})
                                         : (pkt_sum > CMP_BITS'(cfg_i.packet_limit));

  always_comb begin
    pkts_d     = pkts_q;
    bytes_d    = bytes_q;
    t0_d       = t0_q;
    t1_d       = t1_q;
    level      = '0;
    unexpected = 1'b0;
    result_o.status     = ST_ACCEPTED;
    result_o.ecn_out    = item_i.ecn_in;
    result_o.was_marked = 1'b0;

    if (item_i.opcode == OP_ENQUEUE) begin
      if (full) begin
        result_o.status = ST_DROPPED;
      end else begin
        pkts_d  = sat_inc(pkts_q);
        bytes_d = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
        if (cfg_i.per_tenant_counts && (item_i.source_address != cfg_i.tenant_zero_source)) begin
          t1_d = sat_inc(t1_q);
        end else begin
          t0_d = sat_inc(t0_q);
        end
      end
    end else if (pkts_q == '0) begin
      result_o.status  = ST_EMPTY;
      result_o.ecn_out = ECN_NOT_ECT;
    end else begin
      pkts_d  = sat_dec(pkts_q);
      bytes_d = (bytes_q >= {16'd0, item_i.packet_bytes})
                ? bytes_q - {16'd0, item_i.packet_bytes} : 32'd0;
      if (!cfg_i.per_tenant_counts || (item_i.source_address == cfg_i.tenant_zero_source)) begin
        t0_d  = sat_dec(t0_q);
        level = t0_d;
      end else if (item_i.source_address == cfg_i.tenant_one_source) begin
        t1_d  = sat_dec(t1_q);
        level = t1_d;
      end else begin
        unexpected = 1'b1;
      end

      if (unexpected) begin
        result_o.status = ST_UNEXPECTED;
      end else begin
        result_o.status = ST_DEQUEUED;
        if ((CMP_BITS'(level) > CMP_BITS'(cfg_i.count_threshold)) &&
            cfg_i.marking_enabled && (item_i.ecn_in == ECN_ECT_1)) begin
          result_o.ecn_out    = ECN_CE;
          result_o.was_marked = 1'b1;
        end
      end
    end

    result_o.tenant_zero_level = 16'(t0_d[LVL_BITS-1:0]);
    result_o.tenant_one_level  = 16'(t1_d[LVL_BITS-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkts_q  <= '0;
      bytes_q <= '0;
      t0_q    <= '0;
      t1_q    <= '0;
    end else if (commit_i) begin
      pkts_q  <= pkts_d;
      bytes_q <= bytes_d;
      t0_q    <= t0_d;
      t1_q    <= t1_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ecn_count_threshold_marker.sv -----
// ---------------------------------------------------------------------------
// ecn_count_threshold_marker
// Admission and CE-marking control for one externally stored packet FIFO.
// ---------------------------------------------------------------------------
//  channel   handshake                   payload
//  -------   -------------------------   ------------------------------------
//  in        in_valid_i / in_ready_o     opcode, packet_bytes, source, ecn_in
//  out       out_valid_o / out_ready_i   status, ecn_out, was_marked, levels
//  cfg       cfg_we_i (always taken)     cfg_idx_i, cfg_data_i
//
//  One word per cycle while out does not stall; a taken word moves from the
//  input register through the engine into the result register, then out.
//  The counters live in the engine and are updated as a word leaves the input
//  register, so each word sees the state left by the one before it.
//  A stall on out backs up through both registers; in_ready_o drops only
//  when both are full. Reset clears counters and restores register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ecn_count_threshold_marker_assert.svh"

module ecn_count_threshold_marker
  import ecntm_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] packet_bytes_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [1:0]  ecn_in_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [1:0]       ecn_out_o,
  output logic             was_marked_o,
  output logic [15:0]      tenant_zero_level_o,
  output logic [15:0]      tenant_one_level_o
);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_in_bytes     <= RST_LIMIT_IN_BYTES;
      cfg_q.packet_limit       <= RST_PACKET_LIMIT;
      cfg_q.byte_limit         <= RST_BYTE_LIMIT;
      cfg_q.count_threshold    <= RST_COUNT_THRESHOLD;
      cfg_q.per_tenant_counts  <= RST_PER_TENANT_COUNTS;
      cfg_q.marking_enabled    <= RST_MARKING_ENABLED;
      cfg_q.tenant_zero_source <= RST_TENANT_ZERO_SOURCE;
      cfg_q.tenant_one_source  <= RST_TENANT_ONE_SOURCE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIMIT_IN_BYTES:     cfg_q.limit_in_bytes     <= cfg_data_i[0];
        CFG_PACKET_LIMIT:       cfg_q.packet_limit       <= cfg_data_i[15:0];
        CFG_BYTE_LIMIT:         cfg_q.byte_limit         <= cfg_data_i;
        CFG_COUNT_THRESHOLD:    cfg_q.count_threshold    <= cfg_data_i[15:0];
        CFG_PER_TENANT_COUNTS:  cfg_q.per_tenant_counts  <= cfg_data_i[0];
        CFG_MARKING_ENABLED:    cfg_q.marking_enabled    <= cfg_data_i[0];
        CFG_TENANT_ZERO_SOURCE: cfg_q.tenant_zero_source <= cfg_data_i;
        CFG_TENANT_ONE_SOURCE:  cfg_q.tenant_one_source  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: input register -> engine -> result register
  logic    stg_valid_q;
  item_t   stg_item_q;
  logic    advance;      // input register word moves into the result register
  result_t res_comb;
  result_t res_q;

  assign advance    = stg_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_item_q.opcode         <= opcode_e'(opcode_i);
      stg_item_q.packet_bytes   <= packet_bytes_i;
      stg_item_q.source_address <= source_address_i;
      stg_item_q.ecn_in         <= ecn_in_i;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  ecntm_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (stg_item_q),
    .commit_i (advance),
    .result_o (res_comb)
  );

  assign status_o            = res_q.status;
  assign ecn_out_o           = res_q.ecn_out;
  assign was_marked_o        = res_q.was_marked;
  assign tenant_zero_level_o = res_q.tenant_zero_level;
  assign tenant_one_level_o  = res_q.tenant_one_level;

  // Checks
  `ECNTM_ASSERT_NOW(a_mark_only_on_dequeue, clk_i, rst_ni, out_valid_o && was_marked_o, status_o == ST_DEQUEUED && ecn_out_o == ECN_CE)
  `ECNTM_ASSERT_NOW(a_empty_clears_ecn, clk_i, rst_ni, out_valid_o && status_o == ST_EMPTY, ecn_out_o == ECN_NOT_ECT && !was_marked_o)
  `ECNTM_ASSERT_NEXT(a_taken_word_staged, clk_i, rst_ni, in_valid_i && in_ready_o, stg_valid_q)
  `ECNTM_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_o)

endmodule

`default_nettype wire
